[rtl/der_sig_pkg.sv]
// ----------------------------------------------------------------------------
// DER signature parser package
// Item types, result codes and DER constants shared by the parser modules.
// ----------------------------------------------------------------------------
package der_sig_pkg;

  localparam int unsigned MAX_SHORT_LEN_DEF = 127;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] TAG_SEQUENCE  = 8'h30;
  localparam logic [7:0] TAG_INTEGER   = 8'h02;
  localparam logic [7:0] LONG_FORM_BIT = 8'h80;

  localparam logic [1:0] KIND_R      = 2'd0;
  localparam logic [1:0] KIND_S      = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_MALFORMED   = 2'd1;
  localparam logic [1:0] ST_UNSUPPORTED = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [1:0] out_kind;
    logic [7:0] out_byte;
    logic [1:0] out_status;
    logic       out_final;
  } out_item_t;

  typedef struct packed {
    logic      val_vld;
    out_item_t val_item;
    logic      sts_vld;
    out_item_t sts_item;
  } der_sig_res_t;

endpackage

[rtl/der_sig_fsm.sv]
// ----------------------------------------------------------------------------
// DER signature parse engine
// Holds the parse state and turns one accepted byte into at most a value
// result and a final status result.
// ----------------------------------------------------------------------------
module der_sig_fsm
  import der_sig_pkg::*;
#(
  parameter int unsigned MaxShortLen = MAX_SHORT_LEN_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         accept_i,
  input  in_item_t     item_i,
  output der_sig_res_t res_o
);

  localparam logic [2:0] PH_SEQ_TAG = 3'd0;
  localparam logic [2:0] PH_SEQ_LEN = 3'd1;
  localparam logic [2:0] PH_INT_TAG = 3'd2;
  localparam logic [2:0] PH_INT_LEN = 3'd3;
  localparam logic [2:0] PH_INT_VAL = 3'd4;
  localparam logic [2:0] PH_DONE    = 3'd5;
  localparam logic [2:0] PH_ERROR   = 3'd6;

  localparam logic [7:0] MaxLen = 8'(MaxShortLen);

  logic [2:0] phase_q, phase_d;
  logic [6:0] seq_len_q, seq_len_d;
  logic [7:0] consumed_q, consumed_d;
  logic [6:0] rem_q, rem_d;
  logic       which_q, which_d;
  logic       lead_q, lead_d;
  logic [1:0] err_q, err_d;
  logic       hdr_q, hdr_d;

  logic [7:0] b;
  logic [7:0] avail;
  logic       fail;
  logic [1:0] fail_code;
  logic       len_unsup;
  logic       val_vld;
  logic [1:0] status;

  assign b         = item_i.in_byte;
  assign len_unsup = ((b & LONG_FORM_BIT) != 8'd0) || (b > MaxLen);

  always_comb begin
    phase_d    = phase_q;
    seq_len_d  = seq_len_q;
    consumed_d = consumed_q;
    rem_d      = rem_q;
    which_d    = which_q;
    lead_d     = lead_q;
    err_d      = err_q;
    hdr_d      = hdr_q;
    avail      = 8'd0;
    fail       = 1'b0;
    fail_code  = ST_MALFORMED;
    val_vld    = 1'b0;

    if (hdr_q) begin
      if ({1'b0, seq_len_q} > consumed_q) begin
        avail = {1'b0, seq_len_q} - consumed_q;
      end
      if (consumed_q != 8'hFF) begin
        consumed_d = consumed_q + 8'd1;
      end
    end

    unique case (phase_q)
      PH_SEQ_TAG: begin
        if (b == TAG_SEQUENCE) begin
          phase_d = PH_SEQ_LEN;
        end else begin
          fail = 1'b1;
        end
      end
      PH_SEQ_LEN: begin
        if (len_unsup) begin
          fail      = 1'b1;
          fail_code = ST_UNSUPPORTED;
        end else begin
          seq_len_d = b[6:0];
          hdr_d     = 1'b1;
          phase_d   = PH_INT_TAG;
        end
      end
      PH_INT_TAG: begin
        if (avail == 8'd0 || b != TAG_INTEGER) begin
          fail = 1'b1;
        end else begin
          phase_d = PH_INT_LEN;
        end
      end
      PH_INT_LEN: begin
        if (avail == 8'd0) begin
          fail = 1'b1;
        end else if (len_unsup) begin
          fail      = 1'b1;
          fail_code = ST_UNSUPPORTED;
        end else if (b == 8'd0 || b > (avail - 8'd1)) begin
          fail = 1'b1;
        end else begin
          rem_d   = b[6:0];
          lead_d  = 1'b1;
          phase_d = PH_INT_VAL;
        end
      end
      PH_INT_VAL: begin
        if (rem_q != 7'd0) begin
          rem_d = rem_q - 7'd1;
        end
        if (!(lead_q && b == 8'd0 && rem_d != 7'd0)) begin
          lead_d  = 1'b0;
          val_vld = 1'b1;
        end
        if (rem_d == 7'd0) begin
          if (!which_q) begin
            which_d = 1'b1;
            phase_d = PH_INT_TAG;
          end else begin
            phase_d = PH_DONE;
          end
        end
      end
      PH_DONE: begin
        fail = 1'b1;
      end
      default: begin
        phase_d = PH_ERROR;
      end
    endcase

    if (fail) begin
      if (err_q == ST_OK) begin
        err_d = fail_code;
      end
      phase_d = PH_ERROR;
    end
  end

  always_comb begin
    priority if (!hdr_d) begin
      status = (err_d != ST_OK) ? err_d : ST_MALFORMED;
    end else if (consumed_d != {1'b0, seq_len_d}) begin
      status = ST_MALFORMED;
    end else if (err_d != ST_OK) begin
      status = err_d;
    end else if (phase_d != PH_DONE) begin
      status = ST_MALFORMED;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    res_o.val_vld             = accept_i && val_vld;
    res_o.val_item.out_kind   = which_q ? KIND_S : KIND_R;
    res_o.val_item.out_byte   = b;
    res_o.val_item.out_status = ST_OK;
    res_o.val_item.out_final  = 1'b0;
    res_o.sts_vld             = accept_i && item_i.in_last;
    res_o.sts_item.out_kind   = KIND_STATUS;
    res_o.sts_item.out_byte   = 8'd0;
    res_o.sts_item.out_status = status;
    res_o.sts_item.out_final  = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_SEQ_TAG;
      seq_len_q  <= 7'd0;
      consumed_q <= 8'd0;
      rem_q      <= 7'd0;
      which_q    <= 1'b0;
      lead_q     <= 1'b1;
      err_q      <= ST_OK;
      hdr_q      <= 1'b0;
    end else if (accept_i) begin
      if (item_i.in_last) begin
        phase_q    <= PH_SEQ_TAG;
        seq_len_q  <= 7'd0;
        consumed_q <= 8'd0;
        rem_q      <= 7'd0;
        which_q    <= 1'b0;
        lead_q     <= 1'b1;
        err_q      <= ST_OK;
        hdr_q      <= 1'b0;
      end else begin
        phase_q    <= phase_d;
        seq_len_q  <= seq_len_d;
        consumed_q <= consumed_d;
        rem_q      <= rem_d;
        which_q    <= which_d;
        lead_q     <= lead_d;
        err_q      <= err_d;
        hdr_q      <= hdr_d;
      end
    end
  end

endmodule

[rtl/der_ecdsa_signature_parser.sv]
// Results: an item's results are written into the result queue when the item is accepted
// and are offered from the queue's registered storage; the second waits until the first is popped.
// Throughput: one byte item per cycle; up to two results per item leave through
// a four-entry result queue at one per cycle while out_stall_i is low, and input
// stalls when fewer than two entries are free.
// Reset: asynchronous active-low reset clears the parse state and the result queue.
// ----------------------------------------------------------------------------
// DER ECDSA signature parser
// Streams a short-form DER signature value and emits r and s value bytes
// without leading zeros, followed by a final status item.
// ----------------------------------------------------------------------------
module der_ecdsa_signature_parser
  import der_sig_pkg::*;
#(
  parameter int unsigned MaxShortLen = MAX_SHORT_LEN_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  der_sig_res_t res;

  out_item_t  mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q, count_d;

  logic       in_acc;
  logic       pop;
  logic       first_vld;
  logic       second_vld;
  out_item_t  first_item;
  logic [CNT_W-1:0] push_n;

  assign in_stall_o  = count_q > CNT_W'(FIFO_DEPTH - 2);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = count_q != '0;
  assign out_item_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;

  der_sig_fsm #(
    .MaxShortLen(MaxShortLen)
  ) u_fsm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(in_acc),
    .item_i  (in_item_i),
    .res_o   (res)
  );

  assign first_vld  = res.val_vld || res.sts_vld;
  assign second_vld = res.val_vld && res.sts_vld;
  assign first_item = res.val_vld ? res.val_item : res.sts_item;
  assign push_n     = CNT_W'(first_vld) + CNT_W'(second_vld);
  assign count_d    = count_q + push_n - CNT_W'(pop);

  always_ff @(posedge clk_i) begin
    if (first_vld) begin
      mem_q[wr_ptr_q] <= first_item;
    end
    if (second_vld) begin
      mem_q[wr_ptr_q + PTR_W'(1)] <= res.sts_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PTR_W'(push_n);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      count_q <= count_d;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(FIFO_DEPTH))
    else $error("Result queue holds more items than its depth.");

  a_last_gives_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_item_i.in_last) |=> (count_q != '0))
    else $error("Last byte accepted without a queued status item.");

  a_no_push_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc |-> (push_n == '0))
    else $error("Result pushed without an accepted item.");

  a_value_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.out_kind != KIND_STATUS) |->
      (!out_item_o.out_final && out_item_o.out_status == ST_OK))
    else $error("Value item carries status fields.");
`endif

endmodule
